### design/tsfb_pkg.sv
// Shared types, constants and the CRC-8 byte step for the time-sync frame builder.
package tsfb_pkg;

    localparam logic [7:0]  FRAME_MARKER = 8'h55;
    localparam logic [7:0]  FRAME_LEN    = 8'd6;
    localparam logic [7:0]  CRC_POLY     = 8'h8C;
    localparam int          QUEUE_DEPTH  = 2;

    // year / 100 as (year * YEAR_RECIP) >> YEAR_SHIFT, exact for all 14-bit years
    localparam logic [12:0] YEAR_RECIP   = 13'd5243;
    localparam int          YEAR_SHIFT   = 19;

    // byte positions within a frame; the marker goes out as the frame is loaded
    localparam logic [3:0]  POS_LEN    = 4'd1;
    localparam logic [3:0]  POS_SECOND = 4'd2;
    localparam logic [3:0]  POS_MINUTE = 4'd3;
    localparam logic [3:0]  POS_HOUR   = 4'd4;
    localparam logic [3:0]  POS_DAY    = 4'd5;
    localparam logic [3:0]  POS_MONTH  = 4'd6;
    localparam logic [3:0]  POS_YEAR   = 4'd7;
    localparam logic [3:0]  POS_CRC    = 4'd8;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year_mod;
    } t_frame;

    // reflected Dallas/Maxim CRC-8, one byte
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### design/time_sync_frame_builder.sv
// Time-sync frame builder: marker, length, six time bytes and CRC-8 per valid time item.
// The marker byte passes the front-end register, the queue and the output register,
// and the remaining eight bytes follow one per cycle while pop keeps up. The serializer
// takes no new frame until the last one is out; the front end takes a new item every
// cycle until the frame queue and its register stage are full.
// Items with time_valid low are dropped at the input. Reset is synchronous, active low.
module time_sync_frame_builder import tsfb_pkg::*; #(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_time_valid,
    input  logic [5:0]  i_second_value,
    input  logic [5:0]  i_minute_value,
    input  logic [4:0]  i_hour_value,
    input  logic [4:0]  i_day_value,
    input  logic [3:0]  i_month_value,
    input  logic [13:0] i_year_value,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;
    t_frame q_wr_data;
    t_frame q_rd_data;

    tsfb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_time_valid   (i_time_valid),
        .i_second_value (i_second_value),
        .i_minute_value (i_minute_value),
        .i_hour_value   (i_hour_value),
        .i_day_value    (i_day_value),
        .i_month_value  (i_month_value),
        .i_year_value   (i_year_value),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_data       (q_wr_data)
    );

    tsfb_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rd_data)
    );

    tsfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rd_data),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("frame queue written while full");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("frame queue read while empty");

    a_full_only_on_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> q_full)
        else $error("input stalled while the frame queue has room");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result shown right after reset");

endmodule

### design/tsfb_front.sv
// Front end: accepts items, drops those without valid time, reduces the year modulo 100.
module tsfb_front import tsfb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_time_valid,
    input  logic [5:0]  i_second_value,
    input  logic [5:0]  i_minute_value,
    input  logic [4:0]  i_hour_value,
    input  logic [4:0]  i_day_value,
    input  logic [3:0]  i_month_value,
    input  logic [13:0] i_year_value,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_frame      o_q_data
);

    logic        r_s1_valid;
    logic [5:0]  r_second;
    logic [5:0]  r_minute;
    logic [4:0]  r_hour;
    logic [4:0]  r_day;
    logic [3:0]  r_month;
    logic [13:0] r_year;
    logic [7:0]  r_year_q;

    logic        accept;
    logic        s1_go;
    logic [26:0] year_prod;
    logic [13:0] q_times_100;
    logic [13:0] year_rem;

    assign s1_go    = r_s1_valid && !i_q_full;
    assign o_full   = r_s1_valid && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_push = s1_go;

    assign year_prod = 27'(i_year_value) * 27'(YEAR_RECIP);

    // q * 100 = q*64 + q*32 + q*4
    assign q_times_100 = {r_year_q, 6'b0} + {1'b0, r_year_q, 5'b0} + {4'b0, r_year_q, 2'b0};
    assign year_rem    = r_year - q_times_100;

    assign o_q_data = '{second:   r_second,
                        minute:   r_minute,
                        hour:     r_hour,
                        day:      r_day,
                        month:    r_month,
                        year_mod: year_rem[6:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept && i_time_valid) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_time_valid) begin
            r_second <= i_second_value;
            r_minute <= i_minute_value;
            r_hour   <= i_hour_value;
            r_day    <= i_day_value;
            r_month  <= i_month_value;
            r_year   <= i_year_value;
            r_year_q <= year_prod[YEAR_SHIFT +: 8];
        end
    end

endmodule

### design/tsfb_queue.sv
// Small FIFO of reduced frames between the front end and the serializer.
module tsfb_queue import tsfb_pkg::*; #(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_frame o_data
);

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    t_frame             r_mem [P_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(P_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### design/tsfb_back.sv
// Serializer: builds the CRC; one byte per cycle into the output register unless stalled.
module tsfb_back import tsfb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_frame     i_q_data,
    output logic       o_q_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_byte,
    output logic       o_last_byte
);

    logic       r_active;
    logic [3:0] r_idx;
    logic [7:0] r_crc;
    t_frame     r_frame;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       advance;
    logic [7:0] cur_byte;

    assign advance     = !r_out_valid || i_pop;
    assign o_q_pop     = advance && !r_active && !i_q_empty;
    assign o_empty     = !r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;

    always_comb begin
        case (r_idx)
            POS_LEN:    cur_byte = FRAME_LEN;
            POS_SECOND: cur_byte = {2'b0, r_frame.second};
            POS_MINUTE: cur_byte = {2'b0, r_frame.minute};
            POS_HOUR:   cur_byte = {3'b0, r_frame.hour};
            POS_DAY:    cur_byte = {3'b0, r_frame.day};
            POS_MONTH:  cur_byte = {4'b0, r_frame.month};
            POS_YEAR:   cur_byte = {1'b0, r_frame.year_mod};
            POS_CRC:    cur_byte = r_crc;
            default:    cur_byte = r_crc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= POS_LEN;
        end else if (advance) begin
            if (r_active) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= cur_byte;
                r_out_last  <= (r_idx == POS_CRC);
                r_crc       <= crc8_feed(r_crc, cur_byte);
                if (r_idx == POS_CRC) begin
                    r_active <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end else if (!i_q_empty) begin
                // marker leaves as the frame is loaded; CRC excludes it
                r_frame     <= i_q_data;
                r_active    <= 1'b1;
                r_idx       <= POS_LEN;
                r_crc       <= '0;
                r_out_valid <= 1'b1;
                r_out_byte  <= FRAME_MARKER;
                r_out_last  <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
